// File: hdl/msf_pkg.sv
package msf_pkg;

  // Active-low segment codes; bit7 is the decimal point.
  localparam logic [7:0] SEG_BLANK  = 8'hff;
  localparam logic [7:0] SEG_CHAR_F = 8'h8e;
  localparam logic [7:0] SEG_CHAR_U = 8'hc1;
  localparam logic [7:0] SEG_DP     = 8'h80;

  // Status LED bytes, active low.
  localparam logic [7:0] LED_OFF       = 8'hff;
  localparam logic [7:0] LED_VOLT_BASE = 8'hfe;
  localparam logic [7:0] LED_FREQ_BASE = 8'hfd;
  localparam logic [7:0] LED_VBAND     = 8'h04;
  localparam logic [7:0] LED_FBAND     = 8'h08;
  localparam logic [7:0] LED_DAC       = 8'h10;

  // Band thresholds.
  localparam int VBAND_LO  = 150;
  localparam int VBAND_MID = 250;
  localparam int VBAND_HI  = 350;
  localparam int FBAND_LO  = 1000;
  localparam int FBAND_MID = 5000;
  localparam int FBAND_HI  = 10000;

  // Largest frequency the five digits can show.
  localparam int FREQ_MAX = 99999;

  localparam int VOLT_W = 9;
  localparam int FREQ_W = 17;
  localparam int NUM_DIGITS = 8;

  typedef logic [3:0] bcd_t;
  typedef logic [NUM_DIGITS-1:0][7:0] seg_row_t;

  // Decimal digits of one measurement, ready for the segment encoder.
  typedef struct packed {
    logic show;
    logic mode;
    bcd_t [2:0] vd;   // vd[2] hundreds, vd[0] ones
    bcd_t [4:0] fd;   // fd[4] ten-thousands, fd[0] ones
  } disp_t;

  // Digit glyph table; codes above nine stay dark.
  function automatic logic [7:0] seg_digit(bcd_t d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hc0;
      4'd1: s = 8'hf9;
      4'd2: s = 8'ha4;
      4'd3: s = 8'hb0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hf8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/msf_in_if.sv
interface msf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          show_digits;
  logic                          mode;
  logic                          leds_on;
  logic                          dac_follows;
  logic [msf_pkg::VOLT_W-1:0]    voltage;
  logic [msf_pkg::FREQ_W-1:0]    frequency;

  modport source (
    output valid, show_digits, mode, leds_on, dac_follows, voltage, frequency,
    input  ready
  );
  modport sink (
    input  valid, show_digits, mode, leds_on, dac_follows, voltage, frequency,
    output ready
  );
endinterface

// File: hdl/msf_out_if.sv
interface msf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] seg_0;
  logic [7:0] seg_1;
  logic [7:0] seg_2;
  logic [7:0] seg_3;
  logic [7:0] seg_4;
  logic [7:0] seg_5;
  logic [7:0] seg_6;
  logic [7:0] seg_7;
  logic [7:0] led_pattern;

  modport source (
    output valid, seg_0, seg_1, seg_2, seg_3, seg_4, seg_5, seg_6, seg_7, led_pattern,
    input  ready
  );
  modport sink (
    input  valid, seg_0, seg_1, seg_2, seg_3, seg_4, seg_5, seg_6, seg_7, led_pattern,
    output ready
  );
endinterface

// File: hdl/msf_digit.sv
// Peels off the leading decimal digit of a value known to be below ten
// times DIV, using nine parallel compares against multiples of DIV.
module msf_digit #(
  parameter int W   = 17,
  parameter int DIV = 10000,
  parameter int RW  = 14
) (
  input  logic [W-1:0]  x,
  output msf_pkg::bcd_t q,
  output logic [RW-1:0] rem
);

  always_comb begin
    logic [W-1:0] sub;
    q   = '0;
    sub = '0;
    for (int k = 1; k < 10; k++) begin
      if (32'(x) >= 32'(k * DIV)) begin
        q   = 4'(k);
        sub = W'(k * DIV);
      end
    end
    rem = RW'(x - sub);
  end

endmodule

// File: hdl/msf_seg_encode.sv
// Turns the decimal digits into eight segment codes, with the view
// prefix, the decimal point and leading-zero blanking.
module msf_seg_encode (
  input  msf_pkg::disp_t   disp,
  output msf_pkg::seg_row_t seg
);

  logic [4:0] lead;  // lead[i]: every frequency digit from fd[4] down to fd[i] is zero

  always_comb begin
    lead[4] = (disp.fd[4] == 4'd0);
    for (int i = 3; i >= 0; i--) begin
      lead[i] = lead[i+1] && (disp.fd[i] == 4'd0);
    end
  end

  // seg[0] is the leftmost digit.
  always_comb begin
    for (int i = 0; i < msf_pkg::NUM_DIGITS; i++) begin
      seg[i] = msf_pkg::SEG_BLANK;
    end
    if (disp.show) begin
      if (!disp.mode) begin
        seg[0] = msf_pkg::SEG_CHAR_U;
        seg[5] = msf_pkg::seg_digit(disp.vd[2]) & ~msf_pkg::SEG_DP;
        seg[6] = msf_pkg::seg_digit(disp.vd[1]);
        seg[7] = msf_pkg::seg_digit(disp.vd[0]);
      end else begin
        seg[0] = msf_pkg::SEG_CHAR_F;
        for (int i = 0; i < 5; i++) begin
          seg[7-i] = lead[i] ? msf_pkg::SEG_BLANK : msf_pkg::seg_digit(disp.fd[i]);
        end
      end
    end
  end

endmodule

// File: hdl/meter_segment_and_led_formatter.sv
// Formats one voltage or frequency measurement for an eight-digit active-low
// seven-segment display and an active-low status LED byte. The block takes
// one transaction per clock unless a stalled output has filled the pipeline,
// and returns one result per transaction through the four-stage decimal
// digit extraction chain (one frequency digit per stage but the last, which
// takes the tens and ones and also encodes the segments into the output
// register). A stall on the output holds every full stage with no room
// ahead; transactions already in the pipeline are neither lost nor repeated,
// and input is taken again once stage one has room; data needs no reset.
module meter_segment_and_led_formatter (
  input  logic             clk,
  input  logic             rst,
  msf_in_if.sink           in_ch,
  msf_out_if.source        out_ch
);

  typedef struct packed {
    logic          show;
    logic          mode;
    logic [7:0]    led;
    msf_pkg::bcd_t fq4;
    logic [13:0]   frem;
    msf_pkg::bcd_t vh;
    logic [6:0]    vrem;
  } st1_t;

  typedef struct packed {
    logic          show;
    logic          mode;
    logic [7:0]    led;
    msf_pkg::bcd_t fq4;
    msf_pkg::bcd_t fq3;
    logic [9:0]    frem;
    msf_pkg::bcd_t vh;
    msf_pkg::bcd_t vt;
    msf_pkg::bcd_t vo;
  } st2_t;

  typedef struct packed {
    logic          show;
    logic          mode;
    logic [7:0]    led;
    msf_pkg::bcd_t fq4;
    msf_pkg::bcd_t fq3;
    msf_pkg::bcd_t fq2;
    logic [6:0]    frem;
    msf_pkg::bcd_t vh;
    msf_pkg::bcd_t vt;
    msf_pkg::bcd_t vo;
  } st3_t;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  st1_t s1, s1_next;
  st2_t s2, s2_next;
  st3_t s3;
  msf_pkg::disp_t    disp;
  msf_pkg::seg_row_t seg_next;
  logic [7:0] led;

  logic [msf_pkg::FREQ_W-1:0] f_sat;
  logic [3:0] vt_rem;
  logic [3:0] f_ones;
  msf_pkg::bcd_t fq1;
  logic [6:0] s3_frem_next;

  // Stall chain: a stage moves when it is empty or the one ahead moves.
  assign rdy4 = !v4 || out_ch.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ch.ready = rdy1;

  // Stage 1: saturate the frequency, take its first digit and the voltage
  // hundreds, and build the LED byte from the raw measurement.
  assign f_sat = (in_ch.frequency > 17'(msf_pkg::FREQ_MAX)) ?
                 17'(msf_pkg::FREQ_MAX) : in_ch.frequency;

  msf_digit #(.W(17), .DIV(10000), .RW(14)) u_f4 (
    .x(f_sat), .q(s1_next.fq4), .rem(s1_next.frem)
  );
  msf_digit #(.W(9), .DIV(100), .RW(7)) u_vh (
    .x(in_ch.voltage), .q(s1_next.vh), .rem(s1_next.vrem)
  );

  always_comb begin
    logic band_lit;
    led = msf_pkg::LED_OFF;
    band_lit = 1'b0;
    if (in_ch.leds_on) begin
      if (!in_ch.mode) begin
        led = msf_pkg::LED_VOLT_BASE;
        band_lit = !(in_ch.voltage < 9'(msf_pkg::VBAND_LO) ||
                     (in_ch.voltage >= 9'(msf_pkg::VBAND_MID) &&
                      in_ch.voltage < 9'(msf_pkg::VBAND_HI)));
        if (band_lit) begin
          led = led & ~msf_pkg::LED_VBAND;
        end
      end else begin
        led = msf_pkg::LED_FREQ_BASE;
        band_lit = !(in_ch.frequency < 17'(msf_pkg::FBAND_LO) ||
                     (in_ch.frequency >= 17'(msf_pkg::FBAND_MID) &&
                      in_ch.frequency < 17'(msf_pkg::FBAND_HI)));
        if (band_lit) begin
          led = led & ~msf_pkg::LED_FBAND;
        end
      end
      if (in_ch.dac_follows) begin
        led = led & ~msf_pkg::LED_DAC;
      end
    end
  end

  assign s1_next.show = in_ch.show_digits;
  assign s1_next.mode = in_ch.mode;
  assign s1_next.led  = led;

  // Stage 2: thousands digit, voltage tens and ones.
  msf_digit #(.W(14), .DIV(1000), .RW(10)) u_f3 (
    .x(s1.frem), .q(s2_next.fq3), .rem(s2_next.frem)
  );
  msf_digit #(.W(7), .DIV(10), .RW(4)) u_vt (
    .x(s1.vrem), .q(s2_next.vt), .rem(vt_rem)
  );

  assign s2_next.show = s1.show;
  assign s2_next.mode = s1.mode;
  assign s2_next.led  = s1.led;
  assign s2_next.fq4  = s1.fq4;
  assign s2_next.vh   = s1.vh;
  assign s2_next.vo   = vt_rem;

  // Stage 3 splits off the hundreds digit; stage 4 the tens and ones.
  msf_digit #(.W(10), .DIV(100), .RW(7)) u_f2 (
    .x(s2.frem), .q(fq1), .rem(s3_frem_next)
  );

  msf_digit #(.W(7), .DIV(10), .RW(4)) u_f1 (
    .x(s3.frem), .q(disp.fd[1]), .rem(f_ones)
  );

  assign disp.show  = s3.show;
  assign disp.mode  = s3.mode;
  assign disp.vd[2] = s3.vh;
  assign disp.vd[1] = s3.vt;
  assign disp.vd[0] = s3.vo;
  assign disp.fd[4] = s3.fq4;
  assign disp.fd[3] = s3.fq3;
  assign disp.fd[2] = s3.fq2;
  assign disp.fd[0] = f_ones;

  msf_seg_encode u_enc (
    .disp(disp), .seg(seg_next)
  );

  // Valid bits for each stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_ch.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage payloads move together with their valid bits.
  always_ff @(posedge clk) begin
    if (rdy1) s1 <= s1_next;
    if (rdy2) s2 <= s2_next;
    if (rdy3) begin
      s3.show <= s2.show;
      s3.mode <= s2.mode;
      s3.led  <= s2.led;
      s3.fq4  <= s2.fq4;
      s3.fq3  <= s2.fq3;
      s3.fq2  <= fq1;
      s3.frem <= s3_frem_next;
      s3.vh   <= s2.vh;
      s3.vt   <= s2.vt;
      s3.vo   <= s2.vo;
    end
    if (rdy4) begin
      out_ch.seg_0       <= seg_next[0];
      out_ch.seg_1       <= seg_next[1];
      out_ch.seg_2       <= seg_next[2];
      out_ch.seg_3       <= seg_next[3];
      out_ch.seg_4       <= seg_next[4];
      out_ch.seg_5       <= seg_next[5];
      out_ch.seg_6       <= seg_next[6];
      out_ch.seg_7       <= seg_next[7];
      out_ch.led_pattern <= s3.led;
    end
  end

  assign out_ch.valid = v4;

  // An accepted transaction always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> v1)
    else $error("accepted transaction did not reach stage one");

  // A stalled middle stage keeps its transaction.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !rdy3 |=> v2)
    else $error("stage two dropped a stalled transaction");

  // The saturated frequency leaves a remainder below ten thousand.
  a_freq_rem: assert property (@(posedge clk) disable iff (rst)
    v1 |-> s1.frem < 14'd10000)
    else $error("frequency remainder out of range after first digit");

  // Digits switched off give a dark leftmost digit.
  a_dark_digits: assert property (@(posedge clk) disable iff (rst)
    v3 && rdy4 && !s3.show |=> out_ch.seg_0 == msf_pkg::SEG_BLANK)
    else $error("digits lit while display is off");

  // The unused LED bits stay dark.
  a_led_top: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.led_pattern[7:5] == 3'b111)
    else $error("unused LED bits lit");

endmodule

// File: sim/tb_meter_segment_and_led_formatter.sv
module tb_meter_segment_and_led_formatter;

  localparam int ITEM_COUNT  = 1550;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 20;
  localparam int REPORT_MAX  = 10;

  // View select codes on the mode field.
  localparam logic VIEW_VOLT = 1'b0;
  localparam logic VIEW_FREQ = 1'b1;

  // Digit glyphs, active low, digit zero in the lowest byte.
  localparam logic [9:0][7:0] GLYPH = {
    8'h90, 8'h80, 8'hf8, 8'h82, 8'h92, 8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0
  };

  // Digit row with index 0 as the leftmost digit, so literals read left to right.
  typedef logic [0:msf_pkg::NUM_DIGITS-1][7:0] digit_row_t;

  typedef struct packed {
    logic                       show_digits;
    logic                       mode;
    logic                       leds_on;
    logic                       dac_follows;
    logic [msf_pkg::VOLT_W-1:0] voltage;
    logic [msf_pkg::FREQ_W-1:0] frequency;
  } meter_reading_t;

  typedef struct packed {
    digit_row_t seg;
    logic [7:0] led;
  } meter_view_t;

  typedef struct {
    meter_reading_t rd;
    bit             typed;
    meter_view_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  msf_in_if  in_ch();
  msf_out_if out_ch();

  meter_segment_and_led_formatter dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  meter_view_t pending_views[$];
  stim_row_t   stim_table[$];
  int          cycle        = 0;
  int          fail_count   = 0;
  int          items_sent   = 0;
  int          views_seen   = 0;
  int          freq_items   = 0;
  int          clamped      = 0;
  int          steady_left  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected display and LED byte for one measurement.
  function automatic meter_view_t format_display(meter_reading_t rd);
    meter_view_t r;
    int unsigned v;
    int unsigned f;
    int unsigned shown;
    int unsigned div;
    int unsigned d;
    int          i;
    bit          leading;
    bit          band_lit;
    r.seg = {msf_pkg::NUM_DIGITS{msf_pkg::SEG_BLANK}};
    v = 32'(rd.voltage);
    f = 32'(rd.frequency);
    if (rd.show_digits) begin
      if (rd.mode == VIEW_VOLT) begin
        r.seg[0] = msf_pkg::SEG_CHAR_U;
        r.seg[5] = GLYPH[(v / 100) % 10] & ~msf_pkg::SEG_DP;
        r.seg[6] = GLYPH[(v / 10) % 10];
        r.seg[7] = GLYPH[v % 10];
      end else begin
        shown = (f > msf_pkg::FREQ_MAX) ? msf_pkg::FREQ_MAX : f;
        r.seg[0] = msf_pkg::SEG_CHAR_F;
        div = 10000;
        leading = 1'b1;
        // Leading zeros stay dark; a zero value leaves all five dark.
        for (i = 3; i < msf_pkg::NUM_DIGITS; i++) begin
          d = (shown / div) % 10;
          if (!(leading && d == 0)) begin
            leading = 1'b0;
            r.seg[i] = GLYPH[d];
          end
          div = div / 10;
        end
      end
    end
    if (!rd.leds_on) begin
      r.led = msf_pkg::LED_OFF;
    end else begin
      // The band LED toggles at each rising threshold of the active view.
      if (rd.mode == VIEW_VOLT) begin
        r.led = msf_pkg::LED_VOLT_BASE;
        band_lit = !(v < msf_pkg::VBAND_LO ||
                     (v >= msf_pkg::VBAND_MID && v < msf_pkg::VBAND_HI));
        r.led = band_lit ? (r.led & ~msf_pkg::LED_VBAND) : (r.led | msf_pkg::LED_VBAND);
      end else begin
        r.led = msf_pkg::LED_FREQ_BASE;
        band_lit = !(f < msf_pkg::FBAND_LO ||
                     (f >= msf_pkg::FBAND_MID && f < msf_pkg::FBAND_HI));
        r.led = band_lit ? (r.led & ~msf_pkg::LED_FBAND) : (r.led | msf_pkg::LED_FBAND);
      end
      r.led = rd.dac_follows ? (r.led & ~msf_pkg::LED_DAC) : (r.led | msf_pkg::LED_DAC);
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Random measurement, weighted toward short numbers and band edges.
  function automatic meter_reading_t random_reading();
    meter_reading_t rd;
    int             base;
    rd.show_digits = ($urandom_range(7, 0) != 0);
    rd.mode        = $urandom_range(1, 0) ? VIEW_FREQ : VIEW_VOLT;
    rd.leds_on     = ($urandom_range(7, 0) != 0);
    rd.dac_follows = 1'($urandom_range(1, 0));
    case ($urandom_range(3, 0))
      0: rd.voltage = 9'($urandom_range(99, 0));
      1: begin
        base = msf_pkg::VBAND_LO + 100 * $urandom_range(2, 0);
        rd.voltage = 9'(base + $urandom_range(6, 0) - 3);
      end
      default: rd.voltage = 9'($urandom_range(511, 0));
    endcase
    case ($urandom_range(9, 0))
      0: rd.frequency = 17'($urandom_range(9, 0));
      1: rd.frequency = 17'($urandom_range(99, 0));
      2: rd.frequency = 17'($urandom_range(999, 0));
      3: rd.frequency = 17'($urandom_range(9999, 0));
      4, 5: rd.frequency = 17'($urandom_range(msf_pkg::FREQ_MAX, 0));
      6: rd.frequency = 17'($urandom_range(131071, msf_pkg::FREQ_MAX + 1));
      7: begin
        case ($urandom_range(5, 0))
          0: base = msf_pkg::FBAND_LO;
          1: base = msf_pkg::FBAND_MID;
          2: base = msf_pkg::FBAND_HI;
          3: base = msf_pkg::FREQ_MAX;
          4: base = msf_pkg::FREQ_MAX + 1;
          default: base = 131068;
        endcase
        rd.frequency = 17'(base + $urandom_range(6, 0) - 3);
      end
      default: rd.frequency = 17'($urandom_range(131071, 0));
    endcase
    return rd;
  endfunction

  task automatic add_row(input logic show, input logic view, input logic leds,
                         input logic dac, input int volt, input int freq,
                         input bit typed, input digit_row_t seg, input logic [7:0] led);
    stim_row_t row;
    row.rd.show_digits = show;
    row.rd.mode        = view;
    row.rd.leds_on     = leds;
    row.rd.dac_follows = dac;
    row.rd.voltage     = 9'(volt);
    row.rd.frequency   = 17'(freq);
    row.typed          = typed;
    row.want.seg       = seg;
    row.want.led       = led;
    stim_table.push_back(row);
  endtask

  // Drive one transaction and record what it should produce once accepted.
  task automatic send_reading(input meter_reading_t rd, input bit typed,
                              input meter_view_t want);
    int gap;
    if (steady_left == 0 && $urandom_range(99, 0) == 0)
      steady_left = $urandom_range(80, 20);
    if (steady_left > 0) begin
      steady_left--;
      gap = 0;
    end else begin
      gap = idle_gap();
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.show_digits <= rd.show_digits;
    in_ch.mode        <= rd.mode;
    in_ch.leds_on     <= rd.leds_on;
    in_ch.dac_follows <= rd.dac_follows;
    in_ch.voltage     <= rd.voltage;
    in_ch.frequency   <= rd.frequency;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_views.push_back(typed ? want : format_display(rd));
    items_sent++;
    if (rd.mode == VIEW_FREQ) begin
      freq_items++;
      if (rd.frequency > msf_pkg::FREQ_MAX) clamped++;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("cycle %0d: %s mismatch, expected %02h, got %02h", cycle, what, want, got);
  endtask

  // Stimulus: directed table, then random transactions, then drain.
  initial begin : stimulus
    meter_view_t none;
    int          n;
    none = '0;
    in_ch.valid       <= 1'b0;
    in_ch.show_digits <= 1'b0;
    in_ch.mode        <= VIEW_VOLT;
    in_ch.leds_on     <= 1'b0;
    in_ch.dac_follows <= 1'b0;
    in_ch.voltage     <= '0;
    in_ch.frequency   <= '0;

    // Everything dark, then digits off with LEDs on at the far extremes.
    add_row(0, VIEW_VOLT, 0, 0, 0, 0, 1, 64'hffff_ffff_ffff_ffff, 8'hff);
    add_row(0, VIEW_FREQ, 1, 1, 511, 131071, 1, 64'hffff_ffff_ffff_ffff, 8'he5);
    // Voltage view at both ends of the field.
    add_row(1, VIEW_VOLT, 1, 0, 0, 0, 1, 64'hc1ff_ffff_ff40_c0c0, 8'hfe);
    add_row(1, VIEW_VOLT, 1, 1, 511, 131071, 1, 64'hc1ff_ffff_ff12_f9f9, 8'hea);
    // Frequency zero blanks all digits; the top of the field saturates.
    add_row(1, VIEW_FREQ, 1, 0, 0, 0, 1, 64'h8eff_ffff_ffff_ffff, 8'hfd);
    add_row(1, VIEW_FREQ, 1, 1, 0, 131071, 1, 64'h8eff_ff90_9090_9090, 8'he5);
    // Saturation edge and leading zero blanking at one, two, three and five digits.
    add_row(1, VIEW_FREQ, 1, 0, 300, 99999, 0, '0, '0);
    add_row(1, VIEW_FREQ, 1, 1, 300, 100000, 0, '0, '0);
    add_row(1, VIEW_FREQ, 1, 0, 0, 1, 0, '0, '0);
    add_row(1, VIEW_FREQ, 0, 1, 0, 10, 0, '0, '0);
    add_row(1, VIEW_FREQ, 1, 0, 0, 100, 0, '0, '0);
    add_row(1, VIEW_FREQ, 1, 1, 0, 10000, 0, '0, '0);
    // Voltage band edges.
    add_row(1, VIEW_VOLT, 1, 0, 149, 0, 0, '0, '0);
    add_row(1, VIEW_VOLT, 1, 1, 150, 0, 0, '0, '0);
    add_row(1, VIEW_VOLT, 1, 0, 249, 0, 0, '0, '0);
    add_row(1, VIEW_VOLT, 1, 1, 250, 0, 0, '0, '0);
    add_row(1, VIEW_VOLT, 1, 0, 349, 0, 0, '0, '0);
    add_row(1, VIEW_VOLT, 1, 1, 350, 0, 0, '0, '0);
    // Frequency band edges.
    add_row(1, VIEW_FREQ, 1, 0, 0, 999, 0, '0, '0);
    add_row(1, VIEW_FREQ, 1, 1, 0, 1000, 0, '0, '0);
    add_row(1, VIEW_FREQ, 1, 0, 0, 4999, 0, '0, '0);
    add_row(1, VIEW_FREQ, 1, 1, 0, 5000, 0, '0, '0);
    add_row(1, VIEW_FREQ, 1, 0, 0, 9999, 0, '0, '0);
    // LEDs off while digits show a value.
    add_row(1, VIEW_VOLT, 0, 1, 123, 54321, 0, '0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i])
      send_reading(stim_table[i].rd, stim_table[i].typed, stim_table[i].want);
    for (n = 0; n < ITEM_COUNT; n++)
      send_reading(random_reading(), 1'b0, none);
    in_ch.valid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d transactions (%0d frequency view, %0d above the display range).",
             items_sent, freq_items, clamped);
    $display("Checked %0d results; %0d mismatches.", views_seen, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Output side: ready runs of random length broken by random stalls.
  initial begin : result_sink
    int run;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(9, 0) == 0)
        run = $urandom_range(120, 40);
      else
        run = $urandom_range(6, 1);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = idle_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    meter_view_t got;
    meter_view_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.seg = {out_ch.seg_0, out_ch.seg_1, out_ch.seg_2, out_ch.seg_3,
                 out_ch.seg_4, out_ch.seg_5, out_ch.seg_6, out_ch.seg_7};
      got.led = out_ch.led_pattern;
      views_seen++;
      if (pending_views.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("cycle %0d: result with no transaction pending", cycle);
      end else begin
        want = pending_views.pop_front();
        for (int i = 0; i < msf_pkg::NUM_DIGITS; i++)
          if (got.seg[i] !== want.seg[i])
            flag_mismatch($sformatf("seg_%0d", i), want.seg[i], got.seg[i]);
        if (got.led !== want.led)
          flag_mismatch("led_pattern", want.led, got.led);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle, pending_views.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
